// ----- sv/dds_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, register indexes and the quarter-wave sine table builder
// for the DDS function generator. No dependencies.
package dds_pkg;

  localparam int PHASE_BITS      = 32;
  localparam int SINE_TABLE_BITS = 10;
  localparam int TICK_COUNT_BITS = 16;

  localparam int SINE_ENTRIES   = (1 << SINE_TABLE_BITS) + 1;
  localparam int SINE_ADDR_BITS = SINE_TABLE_BITS + 1;
  localparam int WAVE_BITS      = 17;
  localparam int SINE_BITS      = 16;
  localparam int SAMPLE_BITS    = 18;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 32;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned WAVE_ONE    = 64'd32768;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_WAVEFORM  = 3'd0,
    REG_PHASE_INC = 3'd1,
    REG_AMPLITUDE = 3'd2,
    REG_OFFSET    = 3'd3,
    REG_TICK_DIV  = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_SQUARE = 2'd1,
    WAVE_TRI    = 2'd2,
    WAVE_NONE   = 2'd3
  } wave_sel_t;

  typedef logic [SINE_BITS-1:0] sine_tab_t [SINE_ENTRIES];

  // Q30 Taylor series of sin over the first quadrant, rounded to Q1.15
  function automatic logic [SINE_BITS-1:0] quarter_sine(input int unsigned idx);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] p;
    logic [63:0] r;
    logic signed [63:0] sum;
    x = (64'(idx) * HALF_PI_Q30) >> SINE_TABLE_BITS;
    x2 = (x * x) >> 30;
    term = x;
    sum = signed'(x);
    for (int k = 1; k <= 5; k++) begin
      p = (term * x2) >> 30;
      case (k)
        1:       term = p / 64'd6;
        2:       term = p / 64'd20;
        3:       term = p / 64'd42;
        4:       term = p / 64'd72;
        default: term = p / 64'd110;
      endcase
      if (k[0]) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    r = (unsigned'(sum) * WAVE_ONE + (64'd1 << 29)) >> 30;
    if (r > WAVE_ONE) begin
      r = WAVE_ONE;
    end
    return r[SINE_BITS-1:0];
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t t;
    for (int i = 0; i < SINE_ENTRIES; i++) begin
      t[i] = quarter_sine(i);
    end
    return t;
  endfunction

endpackage

// ----- sv/dds_function_generator_core.sv -----
`timescale 1ns / 1ps
// Top level of the DDS function generator: tick divider, phase accumulator,
// wave shaping, amplitude scaling and level detection. Uses dds_pkg, dds_sine_rom.
//
// Usage:
//   in_*  : one transfer per clock tick (in_tick = 1 means a tick passed).
//           A transfer with in_tick = 0 changes nothing.
//   out_* : one result per sampling tick: analog_sample (1/256 knob step),
//           digital_level and level_changed.
//   cfg_* : register writes, index per dds_pkg::cfg_reg_t; cfg_ready is
//           always high. Write only while no sample is in flight.
// Pipeline: a sampling tick's result passes the registered sine ROM read,
//   then the scale-and-offset output register.
// Throughput: one tick per cycle while in_stall is low; the ROM read port
//   and the output register each take one sample per cycle unless stalled.
// Reset: phase, tick counter and level history clear; tick_divisor resets to
//   1, other registers to 0. The first tick after reset samples.
// Stall: an out_stall holds the output register; a second sample queues in
//   the ROM stage, and only when both are full is in_stall raised.
module dds_function_generator_core
  import dds_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_tick,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_analog_sample,
  output logic                          out_digital_level,
  output logic                          out_level_changed,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data
);

  // configuration
  logic [1:0]  waveform_r;
  logic [31:0] phase_inc_r;
  logic [7:0]  amplitude_r;
  logic [7:0]  offset_r;
  logic [15:0] tick_div_r;

  // control state
  logic [PHASE_BITS-1:0]      phase_acc_r;
  logic [TICK_COUNT_BITS-1:0] tick_count_r;
  logic                       level_known_r;
  logic                       last_level_r;

  // ROM stage
  logic                        s1_valid_r;
  logic                        s1_sine_r;
  logic                        s1_neg_r;
  logic signed [WAVE_BITS-1:0] s1_alt_r;
  logic [SINE_BITS-1:0]        sine_q;

  // output stage
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic                          level_r;
  logic                          changed_r;

  logic accept, fire, load_out, s1_adv;

  assign cfg_ready = 1'b1;
  assign load_out  = !out_valid_r || !out_stall;
  assign s1_adv    = !s1_valid_r || load_out;
  assign in_stall  = !s1_adv;
  assign accept    = in_valid && s1_adv;
  assign fire      = accept && in_tick && (tick_count_r == '0);

  // sine addressing
  logic [SINE_TABLE_BITS+1:0]  top;
  logic [SINE_TABLE_BITS-1:0]  idx;
  logic [SINE_ADDR_BITS-1:0]   rom_addr;

  assign top = phase_acc_r[PHASE_BITS-1 -: SINE_TABLE_BITS+2];
  assign idx = top[SINE_TABLE_BITS-1:0];
  assign rom_addr = top[SINE_TABLE_BITS]
                  ? SINE_ADDR_BITS'(1 << SINE_TABLE_BITS) - {1'b0, idx}
                  : {1'b0, idx};

  dds_sine_rom u_rom (
    .clk     (clk),
    .rd_en   (s1_adv),
    .rd_addr (rom_addr),
    .rd_data (sine_q)
  );

  // square and inverted triangle straight from the phase
  logic [15:0]                 tri_u;
  logic [14:0]                 tri_r;
  logic signed [WAVE_BITS-1:0] tri_w;
  logic signed [WAVE_BITS-1:0] alt_w;

  assign tri_u = phase_acc_r[PHASE_BITS-1 -: 16];
  assign tri_r = {tri_u[13:0], 1'b0};

  always_comb begin
    case (tri_u[15:14])
      2'd0:    tri_w = -$signed({2'b00, tri_r});
      2'd1:    tri_w = $signed({2'b00, tri_r}) - 17'sd32768;
      2'd2:    tri_w = $signed({2'b00, tri_r});
      default: tri_w = 17'sd32768 - $signed({2'b00, tri_r});
    endcase
    case (waveform_r)
      WAVE_SQUARE: alt_w = phase_acc_r[PHASE_BITS-1] ? -17'sd32768 : 17'sd32768;
      WAVE_TRI:    alt_w = tri_w;
      default:     alt_w = '0;
    endcase
  end

  // scale and offset
  logic signed [WAVE_BITS-1:0]   wave;
  logic signed [WAVE_BITS+8:0]   prod;
  logic signed [WAVE_BITS+1:0]   term;
  logic signed [SAMPLE_BITS-1:0] sample_nxt;
  logic                          level_nxt;

  assign wave = s1_sine_r
              ? (s1_neg_r ? -$signed({1'b0, sine_q}) : $signed({1'b0, sine_q}))
              : s1_alt_r;
  assign prod = wave * $signed({1'b0, amplitude_r});
  assign term = (WAVE_BITS+2)'(prod >>> 7);
  assign sample_nxt = SAMPLE_BITS'($signed({2'b00, offset_r, 8'h00}) + term);
  assign level_nxt = term > 0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waveform_r    <= '0;
      phase_inc_r   <= '0;
      amplitude_r   <= '0;
      offset_r      <= '0;
      tick_div_r    <= 16'd1;
      phase_acc_r   <= '0;
      tick_count_r  <= '0;
      level_known_r <= 1'b0;
      last_level_r  <= 1'b0;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WAVEFORM:  waveform_r  <= cfg_data[1:0];
          REG_PHASE_INC: phase_inc_r <= cfg_data;
          REG_AMPLITUDE: amplitude_r <= cfg_data[7:0];
          REG_OFFSET:    offset_r    <= cfg_data[7:0];
          REG_TICK_DIV:  tick_div_r  <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (accept && in_tick) begin
        if (tick_count_r != '0) begin
          tick_count_r <= tick_count_r - 1'b1;
        end else begin
          // reload; a divisor of zero acts as one
          tick_count_r <= (tick_div_r == '0) ? '0 : TICK_COUNT_BITS'(tick_div_r - 1'b1);
          phase_acc_r  <= phase_acc_r + PHASE_BITS'(phase_inc_r);
        end
      end
      if (s1_adv) begin
        s1_valid_r <= fire;
      end
      if (load_out) begin
        out_valid_r <= s1_valid_r;
        if (s1_valid_r) begin
          level_known_r <= 1'b1;
          last_level_r  <= level_nxt;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_sine_r <= (waveform_r == WAVE_SINE);
      s1_neg_r  <= top[SINE_TABLE_BITS+1];
      s1_alt_r  <= alt_w;
    end
    if (load_out && s1_valid_r) begin
      sample_r  <= sample_nxt;
      level_r   <= level_nxt;
      changed_r <= !level_known_r || (level_nxt != last_level_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_analog_sample = sample_r;
  assign out_digital_level = level_r;
  assign out_level_changed = changed_r;

endmodule

// ----- sv/dds_sine_rom.sv -----
`timescale 1ns / 1ps
// Quarter-wave sine ROM with a registered read port.
// Depends on dds_pkg for the table builder and sizes.
module dds_sine_rom
  import dds_pkg::*;
(
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [SINE_ADDR_BITS-1:0] rd_addr,
  output logic [SINE_BITS-1:0]      rd_data
);

  localparam sine_tab_t SINE_ROM = build_sine_tab();

  logic [SINE_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= SINE_ROM[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- verif/dds_function_generator_checker.sv -----
`timescale 1ns / 1ps
// Sample checker for the DDS function generator core: follows register writes and
// tick transfers, predicts every sample and compares the result channel. Uses dds_pkg.
module dds_function_generator_checker
  import dds_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          in_tick,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic signed [SAMPLE_BITS-1:0] out_analog_sample,
  input  logic                          out_digital_level,
  input  logic                          out_level_changed,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data,
  output int                            fail_count,
  output int                            pending
);

  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
  localparam int              UNIT_WAVE        = 32768;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   level;
    logic                   changed;
  } sample_t;

  sample_t expected_q[$];
  int      sine_rom [SINE_ENTRIES];

  // Shadow registers and generator state
  wave_sel_t                  wave_sel;
  logic [PHASE_BITS-1:0]      phase_step;
  logic [PHASE_BITS-1:0]      phase_acc;
  logic [7:0]                 amp_code;
  logic [7:0]                 offset_code;
  logic [TICK_COUNT_BITS-1:0] tick_div;
  logic [TICK_COUNT_BITS-1:0] ticks_left;
  logic                       level_known;
  logic                       level_prev;

  // Q30 odd-power series of sin over the first quadrant, rounded to Q1.15
  function automatic int series_sine(input int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned den;
    longint unsigned r;
    longint          acc;
    x = (longint'(k) * QUARTER_TURN_Q30) >> SINE_TABLE_BITS;
    x2 = (x * x) >> 30;
    term = x;
    acc = $signed(x);
    for (int n = 1; n <= 5; n++) begin
      den = 2 * n * (2 * n + 1);
      term = ((term * x2) >> 30) / den;
      if (n % 2 == 1) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    r = ($unsigned(acc) * UNIT_WAVE + (64'd1 << 29)) >> 30;
    if (r > UNIT_WAVE) begin
      r = UNIT_WAVE;
    end
    return int'(r);
  endfunction

  function automatic int wave_at(input logic [PHASE_BITS-1:0] ph);
    logic [SINE_TABLE_BITS+1:0] top;
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [15:0]                u;
    int                         s;
    int                         r;
    int                         ramp;
    top = ph[PHASE_BITS-1 -: SINE_TABLE_BITS+2];
    idx = top[SINE_TABLE_BITS-1:0];
    u = ph[PHASE_BITS-1 -: 16];
    r = int'(u[13:0]) * 2;
    case (wave_sel)
      WAVE_SINE: begin
        // odd quadrants read the table mirrored, the lower half turn negates
        s = sine_rom[top[SINE_TABLE_BITS] ? (1 << SINE_TABLE_BITS) - int'(idx) : int'(idx)];
        return top[SINE_TABLE_BITS+1] ? -s : s;
      end
      WAVE_SQUARE: return ph[PHASE_BITS-1] ? -UNIT_WAVE : UNIT_WAVE;
      WAVE_TRI: begin
        case (u[15:14])
          2'd0:    ramp = r;
          2'd1:    ramp = UNIT_WAVE - r;
          2'd2:    ramp = -r;
          default: ramp = r - UNIT_WAVE;
        endcase
        return -ramp;
      end
      default: return 0;
    endcase
  endfunction

  initial begin
    for (int i = 0; i < SINE_ENTRIES; i++) begin
      sine_rom[i] = series_sine(i);
    end
  end

  always @(posedge clk) begin : track
    int      w;
    longint  prod;
    longint  scaled;
    logic    lvl;
    sample_t got;
    sample_t want;
    if (!rst_n) begin
      wave_sel = WAVE_SINE;
      phase_step = '0;
      amp_code = '0;
      offset_code = '0;
      tick_div = 1;
      phase_acc = '0;
      ticks_left = '0;
      level_known = 1'b0;
      level_prev = 1'b0;
      expected_q.delete();
    end else begin
      // check the result transfer before queueing anything from this edge
      if (out_valid && !out_stall) begin
        got = '{out_analog_sample, out_digital_level, out_level_changed};
        if (expected_q.size() == 0) begin
          $error("unexpected result: analog_sample %0d", $signed(got.sample));
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (got.sample !== want.sample) begin
            $error("analog_sample: expected %0d, got %0d",
                   $signed(want.sample), $signed(got.sample));
            fail_count++;
          end
          if (got.level !== want.level) begin
            $error("digital_level: expected %0b, got %0b", want.level, got.level);
            fail_count++;
          end
          if (got.changed !== want.changed) begin
            $error("level_changed: expected %0b, got %0b", want.changed, got.changed);
            fail_count++;
          end
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WAVEFORM:  wave_sel = wave_sel_t'(cfg_data[1:0]);
          REG_PHASE_INC: phase_step = cfg_data[PHASE_BITS-1:0];
          REG_AMPLITUDE: amp_code = cfg_data[7:0];
          REG_OFFSET:    offset_code = cfg_data[7:0];
          REG_TICK_DIV:  tick_div = cfg_data[TICK_COUNT_BITS-1:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall && in_tick) begin
        if (ticks_left != 0) begin
          ticks_left = ticks_left - 1'b1;
        end else begin
          // reload from the divisor in force now; zero acts as one
          ticks_left = (tick_div == 0) ? '0 : tick_div - 1'b1;
          w = wave_at(phase_acc);
          phase_acc = phase_acc + phase_step;
          prod = longint'(w) * longint'(amp_code);
          scaled = prod >>> 7;
          lvl = scaled > 0;
          want.sample = SAMPLE_BITS'(longint'(offset_code) * 256 + scaled);
          want.level = lvl;
          want.changed = !level_known || (lvl != level_prev);
          level_known = 1'b1;
          level_prev = lvl;
          expected_q.push_back(want);
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

// ----- verif/dds_function_generator_core_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the DDS function generator core: clock, reset, tick and
// register stimulus, output backpressure and verdict. Uses dds_pkg and the checker.
module dds_function_generator_core_tb;
  import dds_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 200;
  localparam int PHASES        = 24;

  logic                          clk;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_tick   = 1'b0;
  logic                          out_stall = 1'b0;
  logic                          cfg_valid = 1'b0;
  logic [CFG_IDX_BITS-1:0]       cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]      cfg_data  = '0;
  logic                          in_stall;
  logic                          out_valid;
  logic signed [SAMPLE_BITS-1:0] out_analog_sample;
  logic                          out_digital_level;
  logic                          out_level_changed;
  logic                          cfg_ready;
  int                            fail_count;
  int                            pending;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_trigger  = 0;
  int cycles        = 0;

  dds_function_generator_core DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_tick           (in_tick),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_analog_sample (out_analog_sample),
    .out_digital_level (out_digital_level),
    .out_level_changed (out_level_changed),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  dds_function_generator_checker sample_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_tick           (in_tick),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_analog_sample (out_analog_sample),
    .out_digital_level (out_digital_level),
    .out_level_changed (out_level_changed),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: random stalls, plus a long hold-off whenever the trigger moves
  initial begin : result_side
    int hold_left;
    int seen_trigger;
    hold_left = 0;
    seen_trigger = 0;
    forever begin
      @(posedge clk);
      if (hold_trigger != seen_trigger) begin
        seen_trigger = hold_trigger;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Offer one tick transfer, idling first at random; returns at the accepting edge
  task automatic send_tick(input logic t);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_tick <= 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_tick <= t;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid, wait for every pending sample, then let the pipeline empty
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [1:0] ws, input logic [31:0] inc,
                                input logic [7:0] amp, input logic [7:0] off,
                                input logic [15:0] div, input bit spare);
    cfg_reg_t    regs [5];
    logic [31:0] vals [5];
    logic [31:0] fill;
    regs = '{REG_WAVEFORM, REG_PHASE_INC, REG_AMPLITUDE, REG_OFFSET, REG_TICK_DIV};
    fill = $urandom;
    // junk in the unused upper bits must be ignored
    vals[0] = {fill[31:2], ws};
    vals[1] = inc;
    vals[2] = {fill[31:8], amp};
    vals[3] = {fill[23:0], off};
    vals[4] = {fill[15:0], div};
    drain();
    if (spare) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_BITS'($urandom_range(REG_TICK_DIV + 1, (1 << CFG_IDX_BITS) - 1));
      cfg_data <= $urandom;
      do @(posedge clk); while (!cfg_ready);
    end
    foreach (regs[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_code();
    case ($urandom_range(0, 11))
      0:       return 8'd0;
      1:       return 8'd200;
      2:       return 8'd255;
      3:       return 8'($urandom_range(201, 255));
      default: return 8'($urandom_range(0, 200));
    endcase
  endfunction

  initial begin : stimulus
    int          n;
    logic [1:0]  ws;
    logic [31:0] inc;
    logic [15:0] div;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: the first tick samples and flags a change
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    // Quarter-turn steps hit both ends of the sine table
    apply_settings(WAVE_SINE, 32'h4000_0000, 8'd200, 8'd100, 16'd1, 1'b0);
    repeat (5) send_tick(1'b1);
    // Full-scale codes, wrapping step, divisor zero
    apply_settings(WAVE_SINE, 32'hFFFF_FFFF, 8'd255, 8'd255, 16'd0, 1'b0);
    repeat (3) send_tick(1'b1);
    apply_settings(WAVE_SQUARE, 32'h8000_0000, 8'd200, 8'd0, 16'd0, 1'b0);
    repeat (3) send_tick(1'b1);
    apply_settings(WAVE_TRI, 32'h2000_0000, 8'd200, 8'd200, 16'd1, 1'b0);
    repeat (4) send_tick(1'b1);
    // Undefined waveform gives the offset alone; write an unused index too
    apply_settings(WAVE_NONE, 32'h1234_5678, 8'd200, 8'd50, 16'd3, 1'b1);
    repeat (4) send_tick(1'b1);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < PHASES / 3) begin
        send_idle_pct = 9;
        recv_idle_pct = 45;
      end else if (ph < 2 * PHASES / 3) begin
        send_idle_pct = 45;
        recv_idle_pct = 9;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      ws = ($urandom_range(0, 9) == 0) ? WAVE_NONE : 2'($urandom_range(0, 2));
      case ($urandom_range(0, 5))
        0:       inc = 32'h0;
        1:       inc = 32'hFFFF_FFFF;
        2:       inc = 32'($urandom_range(1, 1 << 22));
        default: inc = $urandom;
      endcase
      div = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(4, 12))
                                        : 16'($urandom_range(0, 3));
      apply_settings(ws, inc, pick_code(), pick_code(), div, ($urandom_range(0, 3) == 0));
      n = $urandom_range(56, 96);
      repeat (n) send_tick($urandom_range(0, 99) < 85);
    end

    // Hold the result side off while ticks keep coming, so the input backs up
    apply_settings(WAVE_SINE, $urandom, 8'd200, 8'd100, 16'd1, 1'b0);
    hold_trigger++;
    repeat (80) send_tick(1'b1);

    // Largest divisor: one sample now, then the counter runs down from the top
    apply_settings(WAVE_TRI, $urandom, 8'd200, 8'd100, 16'hFFFF, 1'b0);
    repeat (20) send_tick(1'b1);

    drain();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
